[hdl/chh_pkg.sv]
`default_nettype none
package chh_pkg;

  // Capacity of one point set and coordinate width.
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  // Width of a count that can hold MAX_POINTS itself.
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  // Width of an edge vector and of one cross product.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  // One operation on a shift stack; push and pop never come together.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } cross_sign_t;

  typedef enum logic [2:0] {
    PH_LOAD,
    PH_DRAIN,
    PH_HULL,
    PH_REV,
    PH_EMIT_LO,
    PH_SKIP_UP,
    PH_EMIT_UP
  } phase_t;

  // Order by x, then by y.
  function automatic logic pt_less(point_t a, point_t b);
    logic res;
    if (a.x != b.x) begin
      res = ($signed(a.x) < $signed(b.x));
    end else begin
      res = ($signed(a.y) < $signed(b.y));
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/chh_sort_cell.sv]
`default_nettype none
module chh_sort_cell (
  input  wire             clk,
  input  wire             rst,
  input  wire             shift,
  input  wire             in_vld,
  input  chh_pkg::point_t in_pt,
  input  wire             nxt_vld,
  input  chh_pkg::point_t nxt_pt,
  output logic            carry_vld,
  output chh_pkg::point_t carry_pt,
  output logic            vld,
  output chh_pkg::point_t pt
);

  // Control: the cell's occupancy and the item it hands to its neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      carry_vld <= 1'b0;
    end else if (shift) begin
      vld <= nxt_vld;
      carry_vld <= 1'b0;
    end else begin
      carry_vld <= 1'b0;
      if (in_vld) begin
        if (!vld) begin
          vld <= 1'b1;
        end else if (in_pt != pt) begin
          carry_vld <= 1'b1;
        end
      end
    end
  end

  // Payload: keep the smaller point, pass the larger one on; an equal point is merged.
  always_ff @(posedge clk) begin
    if (shift) begin
      pt <= nxt_pt;
    end else if (in_vld) begin
      if (!vld) begin
        pt <= in_pt;
      end else if (chh_pkg::pt_less(in_pt, pt)) begin
        pt <= in_pt;
        carry_pt <= pt;
      end else begin
        carry_pt <= in_pt;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/chh_sorter.sv]
`default_nettype none
module chh_sorter (
  input  wire             clk,
  input  wire             rst,
  input  wire             shift,
  input  wire             ins_vld,
  input  chh_pkg::point_t ins_pt,
  output logic            head_vld,
  output chh_pkg::point_t head_pt
);

  logic            cvld [chh_pkg::MAX_POINTS];
  chh_pkg::point_t cpt  [chh_pkg::MAX_POINTS];
  logic            vld  [chh_pkg::MAX_POINTS];
  chh_pkg::point_t pt   [chh_pkg::MAX_POINTS];

  // A row of insertion cells: points enter at cell 0 and settle in sorted order;
  // in shift mode the row moves toward cell 0, smallest point first.
  for (genvar i = 0; i < chh_pkg::MAX_POINTS; i++) begin : g_cell
    logic            in_vld;
    chh_pkg::point_t in_pt;
    logic            nxt_vld;
    chh_pkg::point_t nxt_pt;

    if (i == 0) begin : g_first
      assign in_vld = ins_vld;
      assign in_pt  = ins_pt;
    end else begin : g_mid
      assign in_vld = cvld[i-1];
      assign in_pt  = cpt[i-1];
    end

    if (i == chh_pkg::MAX_POINTS - 1) begin : g_last
      assign nxt_vld = 1'b0;
      assign nxt_pt  = pt[i];
    end else begin : g_inner
      assign nxt_vld = vld[i+1];
      assign nxt_pt  = pt[i+1];
    end

    chh_sort_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .in_vld   (in_vld),
      .in_pt    (in_pt),
      .nxt_vld  (nxt_vld),
      .nxt_pt   (nxt_pt),
      .carry_vld(cvld[i]),
      .carry_pt (cpt[i]),
      .vld      (vld[i]),
      .pt       (pt[i])
    );
  end

  assign head_vld = vld[0];
  assign head_pt  = pt[0];

endmodule
`default_nettype wire

[hdl/chh_stack_cell.sv]
`default_nettype none
module chh_stack_cell (
  input  wire                clk,
  input  chh_pkg::stack_op_t op,
  input  chh_pkg::point_t    prev_pt,
  input  chh_pkg::point_t    next_pt,
  output chh_pkg::point_t    pt
);

  // A push moves entries away from the top, a pop moves them toward it.
  always_ff @(posedge clk) begin
    if (op.push) begin
      pt <= prev_pt;
    end else if (op.pop) begin
      pt <= next_pt;
    end
  end

endmodule
`default_nettype wire

[hdl/chh_stack.sv]
`default_nettype none
module chh_stack (
  input  wire                clk,
  input  chh_pkg::stack_op_t op,
  input  chh_pkg::point_t    push_pt,
  output chh_pkg::point_t    top_pt,
  output chh_pkg::point_t    second_pt
);

  chh_pkg::point_t pt [chh_pkg::MAX_POINTS];

  // Shift stack: cell 0 is the top, cell 1 the entry below it.
  for (genvar i = 0; i < chh_pkg::MAX_POINTS; i++) begin : g_cell
    chh_pkg::point_t prev_pt;
    chh_pkg::point_t next_pt;

    if (i == 0) begin : g_top
      assign prev_pt = push_pt;
    end else begin : g_below
      assign prev_pt = pt[i-1];
    end

    if (i == chh_pkg::MAX_POINTS - 1) begin : g_bottom
      assign next_pt = pt[i];
    end else begin : g_above
      assign next_pt = pt[i+1];
    end

    chh_stack_cell u_cell (
      .clk    (clk),
      .op     (op),
      .prev_pt(prev_pt),
      .next_pt(next_pt),
      .pt     (pt[i])
    );
  end

  assign top_pt    = pt[0];
  assign second_pt = pt[1];

endmodule
`default_nettype wire

[hdl/chh_cross.sv]
`default_nettype none
module chh_cross (
  input  chh_pkg::point_t      a_pt,
  input  chh_pkg::point_t      b_pt,
  input  chh_pkg::point_t      c_pt,
  output chh_pkg::cross_sign_t sign
);

  logic signed [chh_pkg::DIFF_W-1:0]  ax, ay, bx, by;
  logic signed [chh_pkg::PROD_W-1:0]  p1, p2;
  logic signed [chh_pkg::CROSS_W-1:0] cr;

  // Sign of the turn a -> b -> c, computed exactly.
  always_comb begin
    ax = chh_pkg::DIFF_W'($signed(b_pt.x)) - chh_pkg::DIFF_W'($signed(a_pt.x));
    ay = chh_pkg::DIFF_W'($signed(b_pt.y)) - chh_pkg::DIFF_W'($signed(a_pt.y));
    bx = chh_pkg::DIFF_W'($signed(c_pt.x)) - chh_pkg::DIFF_W'($signed(b_pt.x));
    by = chh_pkg::DIFF_W'($signed(c_pt.y)) - chh_pkg::DIFF_W'($signed(b_pt.y));
    p1 = chh_pkg::PROD_W'(ax) * chh_pkg::PROD_W'(by);
    p2 = chh_pkg::PROD_W'(ay) * chh_pkg::PROD_W'(bx);
    cr = chh_pkg::CROSS_W'(p1) - chh_pkg::CROSS_W'(p2);
    sign.neg  = cr[chh_pkg::CROSS_W-1];
    sign.zero = (cr == '0);
  end

endmodule
`default_nettype wire

[hdl/convex_hull_monotone_chain_top.sv]
`default_nettype none
// Convex hull of a set of 2-D integer points, counter-clockwise from the smallest point.
// Input channel: one point per item (point_x, point_y, last_point), in_valid/in_stall.
// Points are taken one per cycle while loading and sorted on entry by a row of insertion cells;
// exact duplicates merge there. Up to 64 points are kept; further points are ignored
// and points_dropped is then set on every vertex of that set.
// The item with last_point set closes the set. The block then stalls its input:
//   while the last points settle in the sort row,
//   during the chain pass (one push or one pop per cycle on each chain),
//   while it reverses the lower chain,
//   and while it emits each hull vertex and drops the upper chain's end.
// The chain pass is set by the two cross-product units, one per chain, each giving one turn test per cycle.
// Output channel: one vertex per item (vertex_x, vertex_y, last_vertex, points_dropped),
// out_valid/out_stall, from an output register. While out_stall is high a waiting vertex holds
// and emission pauses; the next set can load while the final vertex still waits.
// Reset (rst, synchronous) empties the sort row and the output register and returns
// the block to loading.
module convex_hull_monotone_chain_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire signed [chh_pkg::COORD_BITS-1:0] point_x,
  input  wire signed [chh_pkg::COORD_BITS-1:0] point_y,
  input  wire                               last_point,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [chh_pkg::COORD_BITS-1:0] vertex_x,
  output logic signed [chh_pkg::COORD_BITS-1:0] vertex_y,
  output logic                              last_vertex,
  output logic                              points_dropped
);

  chh_pkg::phase_t phase, phase_next;
  logic [chh_pkg::CNT_W-1:0] count, count_next;
  logic [chh_pkg::CNT_W-1:0] drain, drain_next;
  logic [chh_pkg::CNT_W-1:0] lsz, lsz_next;
  logic [chh_pkg::CNT_W-1:0] usz, usz_next;
  logic [chh_pkg::CNT_W-1:0] rsz, rsz_next;
  logic ovf, ovf_next;

  logic              accept, shift, ins_vld, head_vld, o_free;
  logic              emit, emit_last;
  chh_pkg::point_t   ins_pt, head_pt, emit_pt;
  chh_pkg::point_t   l_top, l_sec, u_top, u_sec, r_top, r_sec;
  chh_pkg::stack_op_t lop, uop, rop;
  chh_pkg::cross_sign_t lcr, ucr;
  logic              lpop, upop;

  assign ins_pt   = {point_x, point_y};
  assign accept   = in_valid && !in_stall;
  assign o_free   = !out_valid || !out_stall;

  chh_sorter u_sorter (
    .clk     (clk),
    .rst     (rst),
    .shift   (shift),
    .ins_vld (ins_vld),
    .ins_pt  (ins_pt),
    .head_vld(head_vld),
    .head_pt (head_pt)
  );

  // Lower and upper chains, and the stack that reverses the lower chain.
  chh_stack u_lower (.clk(clk), .op(lop), .push_pt(head_pt), .top_pt(l_top), .second_pt(l_sec));
  chh_stack u_upper (.clk(clk), .op(uop), .push_pt(head_pt), .top_pt(u_top), .second_pt(u_sec));
  chh_stack u_rev   (.clk(clk), .op(rop), .push_pt(l_top),   .top_pt(r_top), .second_pt(r_sec));

  chh_cross u_lcross (.a_pt(l_sec), .b_pt(l_top), .c_pt(head_pt), .sign(lcr));
  chh_cross u_ucross (.a_pt(u_sec), .b_pt(u_top), .c_pt(head_pt), .sign(ucr));

  // Pop tests: the lower chain needs a strict left turn, the upper one a strict right turn.
  assign lpop = (lsz >= chh_pkg::CNT_W'(2)) && (lcr.neg || lcr.zero);
  assign upop = (usz >= chh_pkg::CNT_W'(2)) && !ucr.neg;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= chh_pkg::PH_LOAD;
      count <= '0;
      drain <= '0;
      lsz   <= '0;
      usz   <= '0;
      rsz   <= '0;
      ovf   <= 1'b0;
    end else begin
      phase <= phase_next;
      count <= count_next;
      drain <= drain_next;
      lsz   <= lsz_next;
      usz   <= usz_next;
      rsz   <= rsz_next;
      ovf   <= ovf_next;
    end
  end

  // Sequencer: load, settle, chain pass, reverse, emit.
  always_comb begin
    phase_next = phase;
    count_next = count;
    drain_next = drain;
    lsz_next   = lsz;
    usz_next   = usz;
    rsz_next   = rsz;
    ovf_next   = ovf;
    lop        = '0;
    uop        = '0;
    rop        = '0;
    shift      = 1'b0;
    ins_vld    = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_pt    = r_top;
    in_stall   = (phase != chh_pkg::PH_LOAD);
    unique case (phase)
      chh_pkg::PH_LOAD: begin
        if (accept) begin
          if (count < chh_pkg::CNT_W'(chh_pkg::MAX_POINTS)) begin
            ins_vld    = 1'b1;
            count_next = count + chh_pkg::CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (last_point) begin
            count_next = '0;
            drain_next = '0;
            phase_next = chh_pkg::PH_DRAIN;
          end
        end
      end
      chh_pkg::PH_DRAIN: begin
        drain_next = drain + chh_pkg::CNT_W'(1);
        if (drain == chh_pkg::CNT_W'(chh_pkg::MAX_POINTS - 1)) begin
          phase_next = chh_pkg::PH_HULL;
        end
      end
      chh_pkg::PH_HULL: begin
        if (!head_vld) begin
          phase_next = chh_pkg::PH_REV;
        end else if (lpop || upop) begin
          if (lpop) begin
            lop.pop  = 1'b1;
            lsz_next = lsz - chh_pkg::CNT_W'(1);
          end
          if (upop) begin
            uop.pop  = 1'b1;
            usz_next = usz - chh_pkg::CNT_W'(1);
          end
        end else begin
          lop.push = 1'b1;
          uop.push = 1'b1;
          shift    = 1'b1;
          lsz_next = lsz + chh_pkg::CNT_W'(1);
          usz_next = usz + chh_pkg::CNT_W'(1);
        end
      end
      chh_pkg::PH_REV: begin
        if (lsz == '0) begin
          phase_next = chh_pkg::PH_EMIT_LO;
        end else begin
          lop.pop  = 1'b1;
          rop.push = 1'b1;
          lsz_next = lsz - chh_pkg::CNT_W'(1);
          rsz_next = rsz + chh_pkg::CNT_W'(1);
        end
      end
      chh_pkg::PH_EMIT_LO: begin
        if (o_free) begin
          emit      = 1'b1;
          emit_pt   = r_top;
          emit_last = (rsz == chh_pkg::CNT_W'(1)) && (usz <= chh_pkg::CNT_W'(2));
          rop.pop   = 1'b1;
          rsz_next  = rsz - chh_pkg::CNT_W'(1);
          if (rsz == chh_pkg::CNT_W'(1)) begin
            if (usz <= chh_pkg::CNT_W'(2)) begin
              usz_next   = '0;
              ovf_next   = 1'b0;
              phase_next = chh_pkg::PH_LOAD;
            end else begin
              phase_next = chh_pkg::PH_SKIP_UP;
            end
          end
        end
      end
      chh_pkg::PH_SKIP_UP: begin
        // The upper chain's top is the largest point, already given by the lower chain.
        uop.pop    = 1'b1;
        usz_next   = usz - chh_pkg::CNT_W'(1);
        phase_next = chh_pkg::PH_EMIT_UP;
      end
      chh_pkg::PH_EMIT_UP: begin
        if (o_free) begin
          emit      = 1'b1;
          emit_pt   = u_top;
          emit_last = (usz == chh_pkg::CNT_W'(2));
          uop.pop   = 1'b1;
          usz_next  = usz - chh_pkg::CNT_W'(1);
          if (usz == chh_pkg::CNT_W'(2)) begin
            usz_next   = '0;
            ovf_next   = 1'b0;
            phase_next = chh_pkg::PH_LOAD;
          end
        end
      end
      default: begin
        phase_next = chh_pkg::PH_LOAD;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      vertex_x       <= emit_pt.x;
      vertex_y       <= emit_pt.y;
      last_vertex    <= emit_last;
      points_dropped <= ovf;
    end
  end

endmodule
`default_nettype wire

[hdl/chh_checker.sv]
`default_nettype none
module chh_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_valid,
  input wire                               in_stall,
  input wire                               last_point,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire signed [chh_pkg::COORD_BITS-1:0] vertex_x,
  input wire signed [chh_pkg::COORD_BITS-1:0] vertex_y,
  input wire                               last_vertex,
  input wire                               points_dropped
);

  // A stalled vertex stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vertex_x) && $stable(vertex_y)
      && $stable(last_vertex) && $stable(points_dropped))
    else $error("stalled vertex changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Closing a set starts the hull work, which holds off further points.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_point |=> in_stall)
    else $error("input taken right after last point");

endmodule

bind convex_hull_monotone_chain_top chh_checker u_chh_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .last_point    (last_point),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .vertex_x      (vertex_x),
  .vertex_y      (vertex_y),
  .last_vertex   (last_vertex),
  .points_dropped(points_dropped)
);
`default_nettype wire
